FILE: design/z_function_engine_core_defines.svh
// ----------------------------------------------------------------------------
// z_function_engine_core_defines
// Assertion macros shared by the checker of the Z-function engine.
// ----------------------------------------------------------------------------
`ifndef Z_FUNCTION_ENGINE_CORE_DEFINES_SVH
`define Z_FUNCTION_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ZFE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zfe check failed");

// next-cycle implication, disabled during reset
`define ZFE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zfe check failed");

// next-cycle implication, live through reset
`define ZFE_ASSERT_NXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("zfe check failed");

`endif

FILE: design/zfe_pkg.sv
// ----------------------------------------------------------------------------
// zfe_pkg
// Types and constants of the Z-function engine.
// ----------------------------------------------------------------------------
package zfe_pkg;

   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 11;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_FINISH = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_NOTDONE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      VAL_ZERO = 2'd0,
      VAL_LEN  = 2'd1,
      VAL_Z    = 2'd2
   } value_sel_type;

   typedef enum logic [2:0] {
      S_IDLE    = 3'd0,
      S_READ    = 3'd1,
      S_Z_START = 3'd2,
      S_Z_REUSE = 3'd3,
      S_Z_ISSUE = 3'd4,
      S_Z_CHECK = 3'd5
   } state_type;

   typedef struct packed {
      logic          append_we;
      logic          z_init;
      logic          z_rd_box;
      logic          z_rd_idx;
      logic          k_load;
      logic          txt_rd;
      logic          k_inc;
      logic          z_write;
      logic          rsp_load;
      value_sel_type rsp_sel;
      status_type    rsp_status;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic computed;
      logic len_zero;
      logic full;
      logic idx_oor;
      logic i_done;
      logic ik_end;
      logic chars_eq;
   } stat_type;

endpackage

FILE: design/z_function_engine_core.sv
// ----------------------------------------------------------------------------
// z_function_engine_core
// Z-function engine: loads a byte string and computes its Z array.
// ----------------------------------------------------------------------------
// Request beats (req_*) carry op, char_in and read_index; result beats
// (rsp_*) carry value and status. Both channels use valid/stall.
// op 0 appends a byte (no result unless the store is full, status 1).
// op 1 computes the Z array over the string and returns its length.
// op 2 returns Z at read_index (status 2 out of range, 3 before finish).
// op 3 is ignored.
// The compare loop of a finish waits on the registered read of the text store
// at each step.
// One request is handled at a time; a new beat is stalled while the core
// works or while a result waits under rsp_stall. A held result keeps its
// value until taken.
// Reset clears the length, the finished flag, the sequencer and the result
// valid; the stores need no clearing.
// ----------------------------------------------------------------------------
module z_function_engine_core
   import zfe_pkg::*;
#(
   parameter int MAX_LEN = 1024
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CHAR_W-1:0]   req_char_in,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [STATUS_W-1:0] rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   zfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   zfe_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_char_in    (req_char_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

FILE: design/zfe_ctrl.sv
// ----------------------------------------------------------------------------
// zfe_ctrl
// Sequencer: decodes request beats and steps the Z-box walk.
// ----------------------------------------------------------------------------
module zfe_ctrl
   import zfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OP_W-1:0]     req_op,
   output logic                req_stall,
   input  stat_type            stat,
   output cmd_type             cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = !stat.rsp_free;
            if (req_valid && stat.rsp_free) begin
               case (op_type'(req_op))
                  OP_APPEND: begin
                     if (stat.full) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_sel    = VAL_ZERO;
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.append_we = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     cmd.z_init = 1'b1;
                     if (stat.len_zero) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_sel    = VAL_LEN;
                        cmd.rsp_status = ST_OK;
                     end else begin
                        state_in = S_Z_START;
                     end
                  end
                  OP_READ: begin
                     if (!stat.computed) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_sel    = VAL_ZERO;
                        cmd.rsp_status = ST_NOTDONE;
                     end else if (stat.idx_oor) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_sel    = VAL_ZERO;
                        cmd.rsp_status = ST_RANGE;
                     end else begin
                        cmd.z_rd_idx = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_sel    = VAL_Z;
            cmd.rsp_status = ST_OK;
            state_in       = S_IDLE;
         end
         S_Z_START: begin
            if (stat.i_done) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_sel    = VAL_LEN;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end else begin
               cmd.z_rd_box = 1'b1;
               state_in     = S_Z_REUSE;
            end
         end
         S_Z_REUSE: begin
            cmd.k_load = 1'b1;
            state_in   = S_Z_ISSUE;
         end
         S_Z_ISSUE: begin
            if (stat.ik_end) begin
               cmd.z_write = 1'b1;
               state_in    = S_Z_START;
            end else begin
               cmd.txt_rd = 1'b1;
               state_in   = S_Z_CHECK;
            end
         end
         S_Z_CHECK: begin
            if (stat.chars_eq) begin
               cmd.k_inc = 1'b1;
               state_in  = S_Z_ISSUE;
            end else begin
               cmd.z_write = 1'b1;
               state_in    = S_Z_START;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/zfe_datapath.sv
// ----------------------------------------------------------------------------
// zfe_datapath
// Text and Z memories, Z-box registers and the result register.
// ----------------------------------------------------------------------------
module zfe_datapath
   import zfe_pkg::*;
#(
   parameter int MAX_LEN = 1024
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CHAR_W-1:0]   req_char_in,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [STATUS_W-1:0] rsp_status,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [CHAR_W-1:0] text_mem [MAX_LEN];
   logic [LW-1:0]     z_mem    [MAX_LEN];

   logic [LW-1:0]       length_ff;
   logic                computed_ff;
   logic [LW-1:0]       i_ff, k_ff, l_ff, r_ff;
   logic [LW-1:0]       z_rd_ff;
   logic [CHAR_W-1:0]   text_a_ff, text_b_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   status_type          rsp_status_ff;

   logic [LW-1:0]       eff_len;
   logic [LW-1:0]       ik_sum;
   logic [LW-1:0]       box_off;
   logic [LW-1:0]       r_gap;
   logic [AW-1:0]       z_rd_addr;
   logic [AW-1:0]       z_wr_addr;
   logic [LW-1:0]       z_wr_data;
   logic [VALUE_W-1:0]  value_in;

   assign eff_len   = computed_ff ? '0 : length_ff;
   assign ik_sum    = i_ff + k_ff;
   assign box_off   = i_ff - l_ff;
   assign r_gap     = r_ff - i_ff;
   assign z_rd_addr = cmd.z_rd_idx ? AW'(req_read_index) : box_off[AW-1:0];
   assign z_wr_addr = cmd.z_init ? '0 : i_ff[AW-1:0];
   assign z_wr_data = cmd.z_init ? '0 : k_ff;

   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign stat.computed = computed_ff;
   assign stat.len_zero = (length_ff == '0);
   assign stat.full     = (eff_len >= LW'(MAX_LEN));
   assign stat.idx_oor  = (32'(req_read_index) >= 32'(length_ff));
   assign stat.i_done   = (i_ff >= length_ff);
   assign stat.ik_end   = (ik_sum >= length_ff);
   assign stat.chars_eq = (text_a_ff == text_b_ff);

   // text store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.append_we) begin
         text_mem[eff_len[AW-1:0]] <= req_char_in;
      end
      if (cmd.txt_rd) begin
         text_a_ff <= text_mem[k_ff[AW-1:0]];
         text_b_ff <= text_mem[ik_sum[AW-1:0]];
      end
   end

   // Z store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.z_init || cmd.z_write) begin
         z_mem[z_wr_addr] <= z_wr_data;
      end
      if (cmd.z_rd_box || cmd.z_rd_idx) begin
         z_rd_ff <= z_mem[z_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         computed_ff <= 1'b0;
      end else if (cmd.append_we) begin
         length_ff   <= eff_len + LW'(1);
         computed_ff <= 1'b0;
      end else if (cmd.z_init) begin
         computed_ff <= 1'b1;
      end
   end

   // Z-box walk registers
   always_ff @(posedge clock) begin
      if (cmd.z_init) begin
         i_ff <= LW'(1);
         l_ff <= '0;
         r_ff <= '0;
      end
      if (cmd.k_load) begin
         if (i_ff < r_ff) begin
            k_ff <= (z_rd_ff < r_gap) ? z_rd_ff : r_gap;
         end else begin
            k_ff <= '0;
         end
      end
      if (cmd.k_inc) begin
         k_ff <= k_ff + LW'(1);
      end
      if (cmd.z_write) begin
         if (ik_sum > r_ff) begin
            l_ff <= i_ff;
            r_ff <= ik_sum;
         end
         i_ff <= i_ff + LW'(1);
      end
   end

   always_comb begin
      case (cmd.rsp_sel)
         VAL_LEN:  value_in = VALUE_W'(length_ff);
         VAL_Z:    value_in = VALUE_W'(z_rd_ff);
         default:  value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff  <= value_in;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: design/zfe_checker.sv
// ----------------------------------------------------------------------------
// zfe_checker
// Port-level checks of the Z-function engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "z_function_engine_core_defines.svh"

module zfe_checker
   import zfe_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [VALUE_W-1:0]  rsp_value,
   input logic [STATUS_W-1:0] rsp_status
);

   `ZFE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_status))

   `ZFE_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_value == '0)

   `ZFE_ASSERT_IMP(a_backpressure, clock, reset, rsp_valid && rsp_stall, req_stall)

   `ZFE_ASSERT_NXT_NR(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind z_function_engine_core zfe_checker u_zfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);

FILE: sim/z_array_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_array_checker
// Watches the request and result channels of the Z-function engine, keeps its
// own copy of the string and Z array, and compares every result beat in order.
// ----------------------------------------------------------------------------
module z_array_checker
   import zfe_pkg::*;
#(
   parameter int MAX_LEN = 1024
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [CHAR_W-1:0]   req_char_in,
   input  logic [INDEX_W-1:0]  req_read_index,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [VALUE_W-1:0]  rsp_value,
   input  logic [STATUS_W-1:0] rsp_status,
   output int unsigned         pending,
   output int unsigned         fail_count
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } z_result_type;

   logic [CHAR_W-1:0]  text_mem [0:MAX_LEN-1];
   logic [VALUE_W-1:0] z_mem    [0:MAX_LEN-1];
   int unsigned        text_len;
   bit                 z_ready;
   z_result_type       z_results_due [$];

   function automatic void build_z_array();
      int unsigned n;
      int unsigned box_l;
      int unsigned box_r;
      int unsigned k;
      n     = text_len;
      box_l = 0;
      box_r = 0;
      if (n == 0) return;
      z_mem[0] = '0;
      for (int unsigned i = 1; i < n; i++) begin
         k = 0;
         // reuse inside the current Z-box
         if (i < box_r) begin
            k = box_r - i;
            if (32'(z_mem[i - box_l]) < k) k = 32'(z_mem[i - box_l]);
         end
         while (i + k < n && text_mem[k] == text_mem[i + k]) k++;
         z_mem[i] = VALUE_W'(k);
         if (i + k > box_r) begin
            box_l = i;
            box_r = i + k;
         end
      end
   endfunction

   function automatic bit z_engine_step(input logic [OP_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch,
                                        input logic [INDEX_W-1:0] idx,
                                        output z_result_type res);
      bit has_rsp;
      has_rsp    = 1'b0;
      res.value  = '0;
      res.status = ST_OK;
      case (op)
         OP_APPEND: begin
            if (z_ready) begin
               text_len = 0;
               z_ready  = 1'b0;
            end
            if (text_len >= MAX_LEN) begin
               res.status = ST_FULL;
               has_rsp    = 1'b1;
            end else begin
               text_mem[text_len] = ch;
               text_len++;
            end
         end
         OP_FINISH: begin
            build_z_array();
            z_ready   = 1'b1;
            res.value = VALUE_W'(text_len);
            has_rsp   = 1'b1;
         end
         OP_READ: begin
            if (!z_ready) res.status = ST_NOTDONE;
            else if (32'(idx) >= text_len) res.status = ST_RANGE;
            else res.value = z_mem[idx];
            has_rsp = 1'b1;
         end
         default: has_rsp = 1'b0;
      endcase
      return has_rsp;
   endfunction

   always @(posedge clock) begin : watch
      z_result_type due;
      if (reset) begin
         text_len   = 0;
         z_ready    = 1'b0;
         fail_count = 0;
         z_results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (z_results_due.size() == 0) begin
               $display("%0t: unexpected result beat, value %0d status %0d",
                        $time, rsp_value, rsp_status);
               fail_count++;
            end else begin
               due = z_results_due.pop_front();
               if (rsp_value !== due.value) begin
                  $display("%0t: value mismatch, expected %0d, actual %0d",
                           $time, due.value, rsp_value);
                  fail_count++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, due.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (z_engine_step(req_op, req_char_in, req_read_index, due))
               z_results_due.push_back(due);
         end
      end
      pending <= z_results_due.size();
   end

endmodule

FILE: sim/tb_z_function_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_z_function_engine_core
// Loads strings into the Z-function engine, finishes and reads them back under
// random request gaps and result stalls; z_array_checker scores every beat.
// ----------------------------------------------------------------------------
module tb_z_function_engine_core;
   import zfe_pkg::*;

   localparam int              MAX_LEN      = 1024;
   localparam int              CLOCK_PERIOD = 8;
   localparam int              LIMIT_CYCLES = 1000000;
   localparam int              TOTAL_BEATS  = 1300;
   localparam int              CALM_TAIL    = 60;
   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [CHAR_W-1:0]   req_char_in;
   logic [INDEX_W-1:0]  req_read_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [VALUE_W-1:0]  rsp_value;
   logic [STATUS_W-1:0] rsp_status;
   int unsigned         pending;
   int unsigned         fail_count;

   int unsigned beat_count;
   bit          sender_calm;
   bit          tail_calm;

   z_function_engine_core #(
      .MAX_LEN(MAX_LEN)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_char_in    (req_char_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status)
   );

   z_array_checker #(
      .MAX_LEN(MAX_LEN)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_char_in    (req_char_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .pending        (pending),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : run_limit
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("tb: failure");
      $finish;
   end

   initial begin : rsp_backpressure
      int unsigned hold;
      int unsigned cycle_no;
      hold     = 0;
      cycle_no = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (!tail_calm && (cycle_no % 1500) >= 300 &&
                      $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [CHAR_W-1:0] rand_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [INDEX_W-1:0] rand_index();
      return INDEX_W'($urandom_range(0, 1023));
   endfunction

   // this task lowers valid only inside a gap, so back-to-back beats keep it high
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [INDEX_W-1:0] idx);
      if (!sender_calm && !tail_calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_char_in    <= ch;
      req_read_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op != OP_UNUSED) beat_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic append_string(input int unsigned len);
      logic [CHAR_W-1:0] sym [0:3];
      logic [CHAR_W-1:0] pat [0:7];
      logic [CHAR_W-1:0] ch;
      int unsigned       mode;
      int unsigned       period;
      for (int s = 0; s < 4; s++) sym[s] = rand_char();
      for (int s = 0; s < 8; s++) pat[s] = sym[$urandom_range(0, 1)];
      mode   = $urandom_range(0, 9);
      period = $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) begin
         if (mode < 4) begin
            ch = pat[i % period];
            if ($urandom_range(0, 15) == 0) ch = sym[$urandom_range(0, 3)];
         end else if (mode < 8) begin
            ch = sym[$urandom_range(0, (mode % 3) + 1)];
         end else begin
            ch = rand_char();
         end
         if ($urandom_range(0, 39) == 0)
            send_beat(OP_UNUSED, rand_char(), rand_index());
         if (i > 0 && $urandom_range(0, 49) == 0)
            send_beat(OP_READ, rand_char(), rand_index());
         send_beat(OP_APPEND, ch, rand_index());
      end
   endtask

   task automatic read_back(input int unsigned len);
      int unsigned        pick;
      logic [INDEX_W-1:0] idx;
      repeat ($urandom_range(0, 6)) begin
         pick = $urandom_range(0, 9);
         if (pick == 0 || len == 0) idx = rand_index();
         else if (pick < 3 && len < MAX_LEN) idx = INDEX_W'($urandom_range(len, 1023));
         else idx = INDEX_W'($urandom_range(0, len - 1));
         send_beat(OP_READ, rand_char(), idx);
      end
   endtask

   initial begin : stimulus
      int unsigned       len;
      int unsigned       cur_len;
      int unsigned       pick;
      int unsigned       target;
      bit                finished;
      logic [CHAR_W-1:0] fill_ch;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_op         <= OP_APPEND;
      req_char_in    <= '0;
      req_read_index <= '0;
      beat_count  = 0;
      sender_calm = 1'b0;
      tail_calm   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // read before finish, finish on empty string, unused op
      send_beat(OP_READ,   8'h00, 10'd0);
      send_beat(OP_FINISH, 8'h00, 10'd0);
      send_beat(OP_READ,   8'hff, 10'd0);
      send_beat(OP_UNUSED, 8'hff, 10'h3ff);
      send_beat(OP_APPEND, 8'h00, 10'h3ff);
      send_beat(OP_APPEND, 8'hff, 10'd0);
      send_beat(OP_APPEND, 8'h00, 10'd0);
      send_beat(OP_READ,   8'h00, 10'd1);
      send_beat(OP_APPEND, 8'hff, 10'd0);
      send_beat(OP_APPEND, 8'h00, 10'd0);
      send_beat(OP_FINISH, 8'hff, 10'h3ff);
      for (int unsigned i = 0; i <= 5; i++) send_beat(OP_READ, 8'h00, INDEX_W'(i));
      send_beat(OP_READ,   8'h00, 10'h3ff);
      // repeated finish, then append after finish starts a new string
      send_beat(OP_FINISH, 8'h00, 10'd0);
      send_beat(OP_READ,   8'h00, 10'd2);
      send_beat(OP_APPEND, 8'h5a, 10'd0);
      send_beat(OP_READ,   8'h00, 10'd0);
      send_beat(OP_FINISH, 8'h00, 10'd0);
      send_beat(OP_READ,   8'h00, 10'd0);
      wait_drained();

      // fill to capacity, overflow, finish and read far indexes
      fill_ch = rand_char();
      for (int unsigned i = 0; i < MAX_LEN; i++)
         send_beat(OP_APPEND, ($urandom_range(0, 63) == 0) ? ~fill_ch : fill_ch,
                   rand_index());
      send_beat(OP_APPEND, rand_char(), rand_index());
      send_beat(OP_APPEND, rand_char(), rand_index());
      send_beat(OP_FINISH, rand_char(), rand_index());
      send_beat(OP_READ, 8'h00, 10'h3ff);
      send_beat(OP_READ, 8'h00, 10'h200);
      send_beat(OP_READ, 8'h00, 10'd1);
      read_back(MAX_LEN);
      finished = 1'b1;
      cur_len  = MAX_LEN;

      target = TOTAL_BEATS;
      while (beat_count < target) begin
         if (target - beat_count < CALM_TAIL) tail_calm = 1'b1;
         sender_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 90) len = $urandom_range(1, 24);
         else if (pick < 98) len = $urandom_range(25, 120);
         else len = $urandom_range(121, 400);
         if (len > target - beat_count) len = target - beat_count;
         if (finished) cur_len = 0;
         append_string(len);
         cur_len  = (cur_len + len > MAX_LEN) ? MAX_LEN : cur_len + len;
         finished = 1'b0;
         // now and then leave the string open so the next one extends it
         if ($urandom_range(0, 14) != 0) begin
            send_beat(OP_FINISH, rand_char(), rand_index());
            finished = 1'b1;
            read_back(cur_len);
            if ($urandom_range(0, 11) == 0) begin
               send_beat(OP_FINISH, rand_char(), rand_index());
               read_back(cur_len);
            end
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end

      tail_calm = 1'b1;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
